>>> rtl/rdi_pkg.sv
// ----------------------------------------------------------------------------
// rdi_pkg: shared constants for the ray/disk intersection block
// Default field widths, queue depth and configuration register indexes.
// ----------------------------------------------------------------------------
package rdi_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_IDX_BITS   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5,
    REG_RADIUS   = 3'd6,
    REG_EPSILON  = 3'd7
  } rdi_reg_e;

endpackage

>>> rtl/ray_disk_intersect.sv
// ----------------------------------------------------------------------------
// ray_disk_intersect: ray against disk intersection test
//
//   channel   direction  signals                           contents
//   s_axis    in         tvalid tready tdata               one ray
//   m_axis    out        tvalid tready tdata tuser         hit result
//   cfg       in         cfg_valid_i cfg_ready_o idx data  disk registers
//
// One ray accepted per cycle unless back-pressure fills the queue; the
// restoring divider in the back end resolves one bit of t per stage.
// A small queue parts the dot-product front from the divider/back end, so
// the front keeps taking rays while the output stalls, until the queue fills.
// Reset clears all valid bits and loads the default disk; no clearing pass.
// ----------------------------------------------------------------------------
module ray_disk_intersect #(
  parameter int COORD_BITS = rdi_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rdi_pkg::FRAC_BITS_DEF,
  localparam int IN_W      = ((6*COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((4*COORD_BITS - 1 + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [IN_W-1:0]                 s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // distance_t, point_x, point_y, point_z
  output logic [OUT_W-1:0]                m_axis_tdata,
  // hit
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rdi_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]           cfg_data_i
);
  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int EW = 1 + (2*C+1) + (2*C+2+F) + 6*C;

  logic [3*C-1:0] center_q, normal_q;
  logic [C-2:0]   radius_q;
  logic [F-1:0]   eps_q;

  logic           q_in_vld, q_in_rdy, q_out_vld, q_out_rdy;
  logic [EW-1:0]  q_in_data, q_out_data;
  logic           hit;
  logic [C-2:0]   t_val;
  logic [3*C-1:0] pnt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      normal_q <= {C'(1) << F, {(2*C){1'b0}}};
      radius_q <= (C-1)'(1) << F;
      eps_q    <= F'(1);
    end else if (cfg_valid_i) begin
      unique case (rdi_pkg::rdi_reg_e'(cfg_index_i))
        rdi_pkg::REG_CENTER_X: center_q[0*C +: C] <= cfg_data_i;
        rdi_pkg::REG_CENTER_Y: center_q[1*C +: C] <= cfg_data_i;
        rdi_pkg::REG_CENTER_Z: center_q[2*C +: C] <= cfg_data_i;
        rdi_pkg::REG_NORMAL_X: normal_q[0*C +: C] <= cfg_data_i;
        rdi_pkg::REG_NORMAL_Y: normal_q[1*C +: C] <= cfg_data_i;
        rdi_pkg::REG_NORMAL_Z: normal_q[2*C +: C] <= cfg_data_i;
        rdi_pkg::REG_RADIUS:   radius_q <= cfg_data_i[C-2:0];
        rdi_pkg::REG_EPSILON:  eps_q    <= cfg_data_i[F-1:0];
        default: ;
      endcase
    end
  end

  rdi_front #(.C(C), .F(F), .EW(EW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata[6*C-1:0]),
    .center_i    (center_q),
    .normal_i    (normal_q),
    .epsilon_i   (eps_q),
    .out_valid_o (q_in_vld),
    .out_ready_i (q_in_rdy),
    .out_data_o  (q_in_data)
  );

  rdi_queue #(.DW(EW), .DEPTH(rdi_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_in_vld),
    .push_ready_o (q_in_rdy),
    .push_data_i  (q_in_data),
    .pop_valid_o  (q_out_vld),
    .pop_ready_i  (q_out_rdy),
    .pop_data_o   (q_out_data)
  );

  rdi_back #(.C(C), .F(F), .EW(EW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_out_vld),
    .in_ready_o  (q_out_rdy),
    .in_data_i   (q_out_data),
    .center_i    (center_q),
    .radius_i    (radius_q),
    .epsilon_i   (eps_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .hit_o       (hit),
    .t_o         (t_val),
    .point_o     (pnt)
  );

  assign m_axis_tuser = hit;
  assign m_axis_tdata = OUT_W'({pnt, t_val});

  a_hit_t_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (C+F)'(t_val) >= (C+F)'(eps_q))
    else $error("hit with t below epsilon");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss result carries nonzero data");
  a_hit_t_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> t_val != '0 || eps_q == '0)
    else $error("hit with zero t under nonzero epsilon");

endmodule

>>> rtl/rdi_queue.sv
// ----------------------------------------------------------------------------
// rdi_queue: small request queue between front and back
// Register-based fifo with valid/ready on both sides.
// ----------------------------------------------------------------------------
module rdi_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = rdi_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop, full;

  assign full         = (cnt_q == CW'(DEPTH));
  assign push_ready_o = !full;
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && !full;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue fill count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != '0)
    else $error("pop from empty queue");

endmodule

>>> rtl/rdi_front.sv
// ----------------------------------------------------------------------------
// rdi_front: dot products and early classification
// Forms N.D and (C-O).N, takes magnitudes and flags parallel, behind and
// out-of-range rays before the division.
// ----------------------------------------------------------------------------
module rdi_front #(
  parameter int C  = rdi_pkg::COORD_BITS_DEF,
  parameter int F  = rdi_pkg::FRAC_BITS_DEF,
  parameter int EW = 1 + (2*C+1) + (2*C+2+F) + 6*C
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [6*C-1:0] in_data_i,
  input  logic [3*C-1:0] center_i,
  input  logic [3*C-1:0] normal_i,
  input  logic [F-1:0]   epsilon_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [EW-1:0]  out_data_o
);
  localparam int DENW = 2*C + 2;
  localparam int NUMW = 2*C + 3;
  localparam int ADW  = 2*C + 1;
  localparam int ANW  = 2*C + 2;
  localparam int NW   = ANW + F;
  localparam int XW   = NW + C + F;

  logic fe;

  logic signed [2*C-1:0] nd_d [3];
  logic signed [2*C:0]   nm_d [3];
  logic signed [C:0]     diff [3];

  logic                  f1_vld_q;
  logic signed [2*C-1:0] nd_q [3];
  logic signed [2*C:0]   nm_q [3];
  logic [6*C-1:0]        od1_q;

  logic                  f2_vld_q;
  logic signed [DENW-1:0] den_d, den_q;
  logic signed [NUMW-1:0] num_d, num_q;
  logic [6*C-1:0]        od2_q;

  logic [DENW-1:0] den_abs;
  logic [NUMW-1:0] num_abs;
  logic [ADW-1:0]  aden;
  logic [NW-1:0]   nn;
  logic            miss;

  logic            f3_vld_q;
  logic [EW-1:0]   ent_q;

  assign fe         = !f3_vld_q || out_ready_i;
  assign in_ready_o = fe;

  for (genvar i = 0; i < 3; i++) begin : g_dot
    logic signed [C-1:0] o_s, d_s, c_s, n_s;
    assign o_s     = $signed(in_data_i[i*C +: C]);
    assign d_s     = $signed(in_data_i[(3+i)*C +: C]);
    assign c_s     = $signed(center_i[i*C +: C]);
    assign n_s     = $signed(normal_i[i*C +: C]);
    assign diff[i] = (C+1)'(c_s) - (C+1)'(o_s);
    assign nd_d[i] = (2*C)'(n_s) * (2*C)'(d_s);
    assign nm_d[i] = (2*C+1)'(diff[i]) * (2*C+1)'(n_s);
  end

  assign den_d = DENW'(nd_q[0]) + DENW'(nd_q[1]) + DENW'(nd_q[2]);
  assign num_d = NUMW'(nm_q[0]) + NUMW'(nm_q[1]) + NUMW'(nm_q[2]);

  assign den_abs = den_q[DENW-1] ? DENW'(-den_q) : DENW'(den_q);
  assign num_abs = num_q[NUMW-1] ? NUMW'(-num_q) : NUMW'(num_q);
  assign aden    = den_abs[ADW-1:0];
  assign nn      = {num_abs[ANW-1:0], {F{1'b0}}};

  // parallel or nearly so, behind the origin, or t beyond the coordinate range
  assign miss = (aden == '0)
             || (XW'(aden) < (XW'(epsilon_i) << F))
             || ((num_q != '0) && (num_q[NUMW-1] != den_q[DENW-1]))
             || (XW'(nn) >= (XW'(aden) << (C-1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
    end else if (fe) begin
      f1_vld_q <= in_valid_i;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fe) begin
      nd_q  <= nd_d;
      nm_q  <= nm_d;
      od1_q <= in_data_i;
      den_q <= den_d;
      num_q <= num_d;
      od2_q <= od1_q;
      ent_q <= {od2_q, nn, aden, miss};
    end
  end

  assign out_valid_o = f3_vld_q;
  assign out_data_o  = ent_q;

endmodule

>>> rtl/rdi_back.sv
// ----------------------------------------------------------------------------
// rdi_back: division, hit point and radius test
// Restoring divider with one quotient bit per stage, then the hit point,
// the squared distance test and the output register.
// ----------------------------------------------------------------------------
module rdi_back #(
  parameter int C  = rdi_pkg::COORD_BITS_DEF,
  parameter int F  = rdi_pkg::FRAC_BITS_DEF,
  parameter int EW = 1 + (2*C+1) + (2*C+2+F) + 6*C
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [EW-1:0]  in_data_i,
  input  logic [3*C-1:0] center_i,
  input  logic [C-2:0]   radius_i,
  input  logic [F-1:0]   epsilon_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           hit_o,
  output logic [C-2:0]   t_o,
  output logic [3*C-1:0] point_o
);
  localparam int ADW = 2*C + 1;
  localparam int NW  = 2*C + 2 + F;
  localparam int QW  = C - 1;
  localparam int PW  = 2*C + 1;
  localparam int TW  = QW + F;

  logic be;

  logic           in_miss;
  logic [ADW-1:0] in_aden;
  logic [NW-1:0]  in_nn;
  logic [6*C-1:0] in_od;

  // divider stages, index k holds the input of step k
  logic           dv_vld_q  [QW+1];
  logic           dv_miss_q [QW+1];
  logic [ADW-1:0] dv_aden_q [QW+1];
  logic [ADW-1:0] dv_rem_q  [QW+1];
  logic [QW-1:0]  dv_nlo_q  [QW+1];
  logic [QW-1:0]  dv_quo_q  [QW+1];
  logic [6*C-1:0] dv_od_q   [QW+1];

  logic                  b1_vld_q, b1_miss_q;
  logic [QW-1:0]         b1_t_q;
  logic [3*C-1:0]        b1_o_q;
  logic signed [2*C-1:0] prod_d [3];
  logic signed [2*C-1:0] prod_q [3];

  logic                  b2_vld_q, b2_miss_q;
  logic [QW-1:0]         b2_t_q;
  logic signed [PW-1:0]  pt_d [3];
  logic signed [PW-1:0]  pt_q [3];
  logic signed [PW-1:0]  loc_d [3];
  logic [2:0]            far_d;
  logic signed [C-1:0]   loc_q [3];

  logic                  b3_vld_q, b3_miss_q;
  logic [QW-1:0]         b3_t_q;
  logic [2*C-1:0]        sq_q [3];
  logic [2*C-1:0]        rr_q;
  logic [C-1:0]          sat_d [3];
  logic [C-1:0]          sat_q [3];

  logic [2*C+1:0]        sum;
  logic                  fin_miss;

  logic                  out_vld_q, hit_q;
  logic [QW-1:0]         t_q;
  logic [3*C-1:0]        pnt_q;

  assign be         = !out_vld_q || out_ready_i;
  assign in_ready_o = be;

  assign {in_od, in_nn, in_aden, in_miss} = in_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (be) begin
      dv_vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      dv_miss_q[0] <= in_miss;
      dv_aden_q[0] <= in_aden;
      dv_rem_q[0]  <= ADW'(in_nn >> QW);
      dv_nlo_q[0]  <= in_nn[QW-1:0];
      dv_quo_q[0]  <= '0;
      dv_od_q[0]   <= in_od;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [ADW:0] rs, rn;
    logic         ge;
    assign rs = {dv_rem_q[k], dv_nlo_q[k][QW-1]};
    assign ge = (rs >= {1'b0, dv_aden_q[k]});
    assign rn = ge ? rs - {1'b0, dv_aden_q[k]} : rs;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (be) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (be) begin
        dv_miss_q[k+1] <= dv_miss_q[k];
        dv_aden_q[k+1] <= dv_aden_q[k];
        dv_rem_q[k+1]  <= rn[ADW-1:0];
        dv_nlo_q[k+1]  <= dv_nlo_q[k] << 1;
        dv_quo_q[k+1]  <= {dv_quo_q[k][QW-2:0], ge};
        dv_od_q[k+1]   <= dv_od_q[k];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_pt
    logic signed [C-1:0] d_s, o_s, c_s;
    logic signed [PW-1:0] loc_abs;
    assign d_s = $signed(dv_od_q[QW][(3+i)*C +: C]);
    assign o_s = $signed(b1_o_q[i*C +: C]);
    assign c_s = $signed(center_i[i*C +: C]);
    assign prod_d[i] = $signed((2*C)'({1'b0, dv_quo_q[QW]})) * (2*C)'(d_s);
    // floor of t*d at the fraction point
    assign pt_d[i]   = PW'(o_s) + PW'(prod_q[i] >>> F);
    assign loc_d[i]  = pt_d[i] - PW'(c_s);
    assign loc_abs   = loc_d[i][PW-1] ? -loc_d[i] : loc_d[i];
    assign far_d[i]  = (loc_abs > $signed(PW'({1'b0, radius_i})));
    // saturate to the coordinate range
    always_comb begin
      if (!pt_q[i][PW-1] && (|pt_q[i][PW-2:C-1])) begin
        sat_d[i] = {1'b0, {(C-1){1'b1}}};
      end else if (pt_q[i][PW-1] && !(&pt_q[i][PW-2:C-1])) begin
        sat_d[i] = {1'b1, {(C-1){1'b0}}};
      end else begin
        sat_d[i] = pt_q[i][C-1:0];
      end
    end
  end

  assign sum = (2*C+2)'(sq_q[0]) + (2*C+2)'(sq_q[1]) + (2*C+2)'(sq_q[2]);
  assign fin_miss = b3_miss_q || (sum > (2*C+2)'(rr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q  <= 1'b0;
      b2_vld_q  <= 1'b0;
      b3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (be) begin
      b1_vld_q  <= dv_vld_q[QW];
      b2_vld_q  <= b1_vld_q;
      b3_vld_q  <= b2_vld_q;
      out_vld_q <= b3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      b1_miss_q <= dv_miss_q[QW] || (TW'(dv_quo_q[QW]) < TW'(epsilon_i));
      b1_t_q    <= dv_quo_q[QW];
      b1_o_q    <= dv_od_q[QW][3*C-1:0];
      prod_q    <= prod_d;
      b2_miss_q <= b1_miss_q || (|far_d);
      b2_t_q    <= b1_t_q;
      pt_q      <= pt_d;
      for (int i = 0; i < 3; i++) begin
        loc_q[i] <= loc_d[i][C-1:0];
      end
      b3_miss_q <= b2_miss_q;
      b3_t_q    <= b2_t_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (2*C)'((2*C)'(loc_q[i]) * (2*C)'(loc_q[i]));
      end
      rr_q      <= (2*C)'(radius_i) * (2*C)'(radius_i);
      sat_q     <= sat_d;
      hit_q     <= !fin_miss;
      t_q       <= fin_miss ? '0 : b3_t_q;
      pnt_q     <= fin_miss ? '0 : {sat_q[2], sat_q[1], sat_q[0]};
    end
  end

  assign out_valid_o = out_vld_q;
  assign hit_o       = hit_q;
  assign t_o         = t_q;
  assign point_o     = pnt_q;

endmodule
